[hdl/mfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mfd_pkg;

    localparam int MARKER_MAX_DEFAULT = 16;
    localparam int HDR_BYTES          = 5;
    localparam int POS_W              = 17;
    localparam int CMP_W              = POS_W + 1;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_LO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_HI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_LEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_EN      = 3'd7;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

    localparam logic [2:0] V_PENDING  = 3'd0;
    localparam logic [2:0] V_ACCEPT   = 3'd1;
    localparam logic [2:0] V_SHORT    = 3'd2;
    localparam logic [2:0] V_PREFIX   = 3'd3;
    localparam logic [2:0] V_LONG     = 3'd4;
    localparam logic [2:0] V_SUFFIX   = 3'd5;
    localparam logic [2:0] V_DISABLED = 3'd6;

    typedef struct packed {
        logic [63:0] prefix_lo;
        logic [63:0] prefix_hi;
        logic [63:0] suffix_lo;
        logic [63:0] suffix_hi;
        logic [4:0]  pfx_count;
        logic [4:0]  sfx_count;
        logic [15:0] max_payload;
        logic        rx_enabled;
    } cfg_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       in_frame;
        logic       packet_end;
        logic [2:0] verdict;
    } res_t;

    function automatic logic [7:0] marker_byte(input logic [63:0] lo, input logic [63:0] hi,
                                               input logic [3:0] idx);
        logic [63:0] w;
        w = idx[3] ? hi : lo;
        return w[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

[hdl/marked_frame_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Frame extractor for length-prefixed packets carried between marker strings.
// Input stream: one raw packet byte per beat on s_tdata, s_tlast on the final
// byte. Output stream: one beat per input beat carrying the same byte, an
// in-frame flag (header or payload) and, on the tlast beat, the verdict for
// the whole packet; earlier beats carry verdict pending.
// Prefix, suffix, their lengths, the payload limit and the enable are written
// through the cfg_wen / cfg_index / cfg_wdata port. The user must write them
// only while the stream is idle; the block does not enforce it. Throughput is one
// byte per cycle while m_tready stays high. A beat passes the input register, where
// the compare and count logic works on the byte, and then the output register.
// When the receiver holds m_tready low the output register keeps its beat, the
// input register fills behind it and s_tready then falls until the stall ends.
// A synchronous reset (aresetn low) empties both registers, clears the packet
// position and match state, and loads the register defaults (payload limit 1024,
// receiver disabled, no prefix or suffix).

module marked_frame_deframer
    import mfd_pkg::*;
#(
    parameter int MARKER_MAX_BYTES = MARKER_MAX_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // raw_byte
    input  wire logic                  s_tlast,   // last_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // frame_byte
    output logic [3:0]                 m_tuser,   // [0] in_frame, [3:1] verdict
    output logic                       m_tlast,   // packet_end
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg;
    res_t res;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    logic       out_free, advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    mfd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mfd_frame_core #(
        .MARKER_MAX_BYTES (MARKER_MAX_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .raw_byte  (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.frame_byte;
    assign m_tuser  = {out_res_reg.verdict, out_res_reg.in_frame};
    assign m_tlast  = out_res_reg.packet_end;

    // A verdict appears on the closing beat of a packet and only there.
    a_verdict_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[3:1] != V_PENDING)
        else $error("closing beat without a verdict");

    a_pending_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[3:1] == V_PENDING)
        else $error("verdict given before the closing beat");

    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[3:1] <= V_DISABLED)
        else $error("verdict code out of range");

    // The core state only moves when a beat is handed on to the output register.
    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg)
        else $error("input beat dropped while the output stalled");

endmodule

`default_nettype wire

[hdl/mfd_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module mfd_cfg_regs
    import mfd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prefix_lo   <= '0;
            cfg_reg.prefix_hi   <= '0;
            cfg_reg.suffix_lo   <= '0;
            cfg_reg.suffix_hi   <= '0;
            cfg_reg.pfx_count   <= '0;
            cfg_reg.sfx_count   <= '0;
            cfg_reg.max_payload <= MAX_PAYLOAD_RESET;
            cfg_reg.rx_enabled  <= 1'b0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_PREFIX_LO:  cfg_reg.prefix_lo   <= cfg_wdata;
                CFG_PREFIX_HI:  cfg_reg.prefix_hi   <= cfg_wdata;
                CFG_SUFFIX_LO:  cfg_reg.suffix_lo   <= cfg_wdata;
                CFG_SUFFIX_HI:  cfg_reg.suffix_hi   <= cfg_wdata;
                CFG_PREFIX_LEN: cfg_reg.pfx_count   <= cfg_wdata[4:0];
                CFG_SUFFIX_LEN: cfg_reg.sfx_count   <= cfg_wdata[4:0];
                CFG_MAX_PAY:    cfg_reg.max_payload <= cfg_wdata[15:0];
                CFG_RX_EN:      cfg_reg.rx_enabled  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hdl/mfd_frame_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module mfd_frame_core
    import mfd_pkg::*;
#(
    parameter int MARKER_MAX_BYTES = MARKER_MAX_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] raw_byte,
    input  wire logic       last_byte,
    input  wire cfg_t       cfg,
    output res_t            res
);

    localparam logic [4:0] MARK_LIM = 5'(MARKER_MAX_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      hlen_reg, hlen_next;
    logic             pmatch_reg, pmatch_next;
    logic             smatch_reg, smatch_next;

    logic [4:0]       pl, sl;
    logic [CMP_W-1:0] pos_w, hdr_end, frame_end, sfx_end, sfx_off;
    logic [CMP_W-1:0] len, min_len, full_len;
    logic             in_prefix, in_header, in_payload, in_suffix;
    logic [POS_W-1:0] hdr_off;
    logic [2:0]       verdict;

    always_comb begin
        pl = (cfg.pfx_count > MARK_LIM) ? MARK_LIM : cfg.pfx_count;
        sl = (cfg.sfx_count > MARK_LIM) ? MARK_LIM : cfg.sfx_count;

        pos_w     = {1'b0, pos_reg};
        hdr_end   = CMP_W'(pl) + CMP_W'(HDR_BYTES);
        frame_end = hdr_end + CMP_W'(hlen_reg);
        sfx_end   = frame_end + CMP_W'(sl);
        sfx_off   = pos_w - frame_end;
        hdr_off   = pos_reg - POS_W'(pl);

        in_prefix  = pos_w < CMP_W'(pl);
        in_header  = !in_prefix && (pos_w < hdr_end);
        in_payload = !in_prefix && !in_header && (pos_w < frame_end);
        in_suffix  = !in_prefix && !in_header && !in_payload && (pos_w < sfx_end);

        pmatch_next = pmatch_reg;
        smatch_next = smatch_reg;
        hlen_next   = hlen_reg;

        if (in_prefix && (marker_byte(cfg.prefix_lo, cfg.prefix_hi, pos_reg[3:0]) != raw_byte))
            pmatch_next = 1'b0;
        if (in_suffix && (marker_byte(cfg.suffix_lo, cfg.suffix_hi, sfx_off[3:0]) != raw_byte))
            smatch_next = 1'b0;
        if (in_header && (hdr_off == POS_W'(3)))
            hlen_next = {hlen_reg[15:8], raw_byte};
        if (in_header && (hdr_off == POS_W'(4)))
            hlen_next = {raw_byte, hlen_reg[7:0]};

        // The verdict sees the header length and match flags including this beat.
        len      = pos_w + CMP_W'(1);
        min_len  = hdr_end + CMP_W'(sl);
        full_len = min_len + CMP_W'(hlen_next);

        verdict = V_PENDING;
        if (last_byte) begin
            priority if (len < min_len)             verdict = V_SHORT;
            else if (!pmatch_next)                  verdict = V_PREFIX;
            else if (hlen_next > cfg.max_payload)   verdict = V_LONG;
            else if (len < full_len)                verdict = V_SHORT;
            else if (!smatch_next)                  verdict = V_SUFFIX;
            else if (!cfg.rx_enabled)               verdict = V_DISABLED;
            else                                    verdict = V_ACCEPT;
        end

        pos_next = pos_reg;
        if (last_byte) begin
            pos_next    = '0;
            hlen_next   = '0;
            pmatch_next = 1'b1;
            smatch_next = 1'b1;
        end else if (pos_reg < POS_MAX) begin
            pos_next = pos_reg + POS_W'(1);
        end

        res.frame_byte = raw_byte;
        res.in_frame   = in_header || in_payload;
        res.packet_end = last_byte;
        res.verdict    = verdict;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            hlen_reg   <= '0;
            pmatch_reg <= 1'b1;
            smatch_reg <= 1'b1;
        end else if (step) begin
            pos_reg    <= pos_next;
            hlen_reg   <= hlen_next;
            pmatch_reg <= pmatch_next;
            smatch_reg <= smatch_next;
        end
    end

endmodule

`default_nettype wire

[verif/marked_frame_deframer_tb.sv]
`timescale 1ns / 1ps

module marked_frame_deframer_tb;
    import mfd_pkg::*;

    localparam int MARKER_BYTES = MARKER_MAX_DEFAULT;
    localparam int SEGMENTS     = 9;
    localparam int SEG_BEATS    = 110;
    localparam int DIR_ROWS     = 38;

    typedef struct packed {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [63:0]          value;
        logic [7:0]           data;
        logic                 fin;
        logic                 typed;
        logic                 in_frame;
        logic [2:0]           verdict;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic [3:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Copy of the deframer: register set and per-packet state.
    cfg_t        rx_cfg;
    int unsigned rx_pos;
    logic [15:0] rx_hdr_len;
    logic        rx_prefix_ok;
    logic        rx_suffix_ok;

    res_t        expected_beats[$];
    logic [8:0]  pending_bytes[$];
    int          error_count = 0;
    int unsigned src_idle    = 0;
    int unsigned snk_idle    = 0;

    marked_frame_deframer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned marker_span(input logic [4:0] len);
        return (len > MARKER_BYTES) ? MARKER_BYTES : len;
    endfunction

    function automatic logic [7:0] marker_at(input logic [63:0] lo, input logic [63:0] hi,
                                             input int unsigned idx);
        logic [127:0] both;
        both = {hi, lo};
        return both[idx*8 +: 8];
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [4:0] random_marker_len();
        case ($urandom_range(3))
            0: return 5'd0;
            1: return 5'd16;
            2: return 5'($urandom_range(17, 31));
            default: return 5'($urandom_range(1, 15));
        endcase
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [63:0] value);
        dir_row_t r;
        r         = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.value   = value;
        return r;
    endfunction

    function automatic dir_row_t beat_row(input logic [7:0] data, input logic fin,
                                          input logic typed, input logic in_frame,
                                          input logic [2:0] verdict);
        dir_row_t r;
        r          = '0;
        r.data     = data;
        r.fin      = fin;
        r.typed    = typed;
        r.in_frame = in_frame;
        r.verdict  = verdict;
        return r;
    endfunction

    function automatic void clear_packet_state();
        rx_pos       = 0;
        rx_hdr_len   = '0;
        rx_prefix_ok = 1'b1;
        rx_suffix_ok = 1'b1;
    endfunction

    // Works out the output beat for one accepted byte and advances the packet state.
    function automatic res_t predict_beat(input logic [7:0] b, input logic fin);
        int unsigned pl;
        int unsigned sl;
        int unsigned pos;
        int unsigned frame_end;
        int unsigned len;
        res_t        r;
        pl           = marker_span(rx_cfg.pfx_count);
        sl           = marker_span(rx_cfg.sfx_count);
        pos          = rx_pos;
        r.frame_byte = b;
        r.in_frame   = 1'b0;
        r.packet_end = fin;
        r.verdict    = V_PENDING;
        if (pos < pl) begin
            if (marker_at(rx_cfg.prefix_lo, rx_cfg.prefix_hi, pos) != b)
                rx_prefix_ok = 1'b0;
        end else if (pos < pl + HDR_BYTES) begin
            r.in_frame = 1'b1;
            if (pos - pl == 3)
                rx_hdr_len[7:0] = b;
            else if (pos - pl == 4)
                rx_hdr_len[15:8] = b;
        end else begin
            frame_end = pl + HDR_BYTES + rx_hdr_len;
            if (pos < frame_end) begin
                r.in_frame = 1'b1;
            end else if (pos < frame_end + sl) begin
                if (marker_at(rx_cfg.suffix_lo, rx_cfg.suffix_hi, pos - frame_end) != b)
                    rx_suffix_ok = 1'b0;
            end
        end
        if (fin) begin
            len = pos + 1;
            if (len < pl + HDR_BYTES + sl)
                r.verdict = V_SHORT;
            else if (!rx_prefix_ok)
                r.verdict = V_PREFIX;
            else if (rx_hdr_len > rx_cfg.max_payload)
                r.verdict = V_LONG;
            else if (len < pl + HDR_BYTES + rx_hdr_len + sl)
                r.verdict = V_SHORT;
            else if (!rx_suffix_ok)
                r.verdict = V_SUFFIX;
            else if (!rx_cfg.rx_enabled)
                r.verdict = V_DISABLED;
            else
                r.verdict = V_ACCEPT;
            clear_packet_state();
        end else if (rx_pos < POS_MAX) begin
            rx_pos++;
        end
        return r;
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_beats.push_back(predict_beat(b, fin));
    endtask

    // Waits for every outstanding beat, then for the two-stage pipeline to settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_PREFIX_LO:  rx_cfg.prefix_lo   = value;
            CFG_PREFIX_HI:  rx_cfg.prefix_hi   = value;
            CFG_SUFFIX_LO:  rx_cfg.suffix_lo   = value;
            CFG_SUFFIX_HI:  rx_cfg.suffix_hi   = value;
            CFG_PREFIX_LEN: rx_cfg.pfx_count   = value[4:0];
            CFG_SUFFIX_LEN: rx_cfg.sfx_count   = value[4:0];
            CFG_MAX_PAY:    rx_cfg.max_payload = value[15:0];
            default:        rx_cfg.rx_enabled  = value[0];
        endcase
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure_segment(input int seg);
        logic [4:0]  plen;
        logic [4:0]  slen;
        logic [15:0] maxp;
        logic        en;
        if (seg == 0) begin
            plen = 5'd16;
            slen = 5'd31;
            maxp = 16'hFFFF;
            en   = 1'b1;
        end else if (seg == 1) begin
            plen = 5'd0;
            slen = 5'd0;
            maxp = 16'd0;
            en   = 1'b1;
        end else begin
            plen = random_marker_len();
            slen = random_marker_len();
            case ($urandom_range(3))
                0: maxp = 16'd0;
                1: maxp = 16'hFFFF;
                2: maxp = 16'($urandom_range(0, 32));
                default: maxp = 16'($urandom);
            endcase
            en = ($urandom_range(99) < 85);
        end
        drain_results();
        write_reg(CFG_PREFIX_LO, rand64());
        write_reg(CFG_PREFIX_HI, rand64());
        write_reg(CFG_SUFFIX_LO, rand64());
        write_reg(CFG_SUFFIX_HI, rand64());
        // Unused upper bits carry junk on purpose.
        write_reg(CFG_PREFIX_LEN, (rand64() & ~64'h1F) | 64'(plen));
        write_reg(CFG_SUFFIX_LEN, (rand64() & ~64'h1F) | 64'(slen));
        write_reg(CFG_MAX_PAY, (rand64() & ~64'hFFFF) | 64'(maxp));
        write_reg(CFG_RX_EN, (rand64() & ~64'h1) | 64'(en));
    endtask

    // Mostly well-formed packets for the current registers, with some marker
    // corruption, truncation, trailing bytes and plain noise mixed in.
    task automatic build_packet();
        int unsigned pl;
        int unsigned sl;
        int unsigned kind;
        int unsigned npay;
        int unsigned sfx_at;
        int unsigned cut;
        int unsigned i;
        logic [15:0] decl;
        logic [8:0]  pk[$];
        pl   = marker_span(rx_cfg.pfx_count);
        sl   = marker_span(rx_cfg.sfx_count);
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 12)) pk.push_back({1'b0, 8'($urandom_range(255))});
        end else begin
            for (i = 0; i < pl; i++)
                pk.push_back({1'b0, marker_at(rx_cfg.prefix_lo, rx_cfg.prefix_hi, i)});
            if (kind < 18 && pl != 0) begin
                i     = $urandom_range(pl - 1);
                pk[i] = pk[i] ^ (9'd1 << $urandom_range(7));
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: decl = 16'($urandom_range(0, 20));
                6, 7: decl = rx_cfg.max_payload + 16'($urandom_range(1));
                8: decl = 16'($urandom);
                default: decl = 16'hFFFF;
            endcase
            repeat (3) pk.push_back({1'b0, 8'($urandom_range(255))});
            pk.push_back({1'b0, decl[7:0]});
            pk.push_back({1'b0, decl[15:8]});
            npay = (decl > 64) ? $urandom_range(0, 8) : decl;
            repeat (npay) pk.push_back({1'b0, 8'($urandom_range(255))});
            sfx_at = pk.size();
            for (i = 0; i < sl; i++)
                pk.push_back({1'b0, marker_at(rx_cfg.suffix_lo, rx_cfg.suffix_hi, i)});
            if (kind >= 18 && kind < 28 && sl != 0) begin
                i     = sfx_at + $urandom_range(sl - 1);
                pk[i] = pk[i] ^ (9'd1 << $urandom_range(7));
            end
            if (kind >= 28 && kind < 36)
                repeat ($urandom_range(1, 4)) pk.push_back({1'b0, 8'($urandom_range(255))});
            if (kind >= 36 && kind < 46) begin
                cut = $urandom_range(1, pk.size());
                while (pk.size() > cut) void'(pk.pop_back());
            end
        end
        pk[pk.size()-1][8] = 1'b1;
        foreach (pk[j]) pending_bytes.push_back(pk[j]);
    endtask

    always @(posedge aclk) begin : result_check
        res_t got;
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.frame_byte = m_tdata;
                got.in_frame   = m_tuser[0];
                got.packet_end = m_tlast;
                got.verdict    = m_tuser[3:1];
                if (expected_beats.size() == 0) begin
                    if (error_count < 10)
                        $display("%0t: output beat %02h with nothing outstanding",
                                 $realtime, got.frame_byte);
                    error_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (got.frame_byte !== want.frame_byte || got.in_frame !== want.in_frame ||
                        got.packet_end !== want.packet_end || got.verdict !== want.verdict) begin
                        if (error_count < 10)
                            $display({"%0t: expected byte %02h in_frame %0b end %0b verdict %0d,",
                                      " got byte %02h in_frame %0b end %0b verdict %0d"},
                                     $realtime, want.frame_byte, want.in_frame,
                                     want.packet_end, want.verdict, got.frame_byte,
                                     got.in_frame, got.packet_end, got.verdict);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    initial begin : watchdog
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        dir_row_t    dir_rows [DIR_ROWS];
        res_t        typed_res;
        logic [8:0]  nb;
        int unsigned phase;

        rx_cfg             = '0;
        rx_cfg.max_payload = MAX_PAYLOAD_RESET;
        clear_packet_state();
        src_idle = 11;
        snk_idle = 61;

        dir_rows = '{
            // Reset registers: no markers, payload limit 1024, receiver off.
            beat_row(8'hFF, 1'b1, 1'b1, 1'b1, V_SHORT),
            // Declared payload 0xFFFF is over the reset limit.
            beat_row(8'h00, 1'b0, 1'b1, 1'b1, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'hFF, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'hFF, 1'b1, 1'b1, 1'b1, V_LONG),
            beat_row(8'h00, 1'b0, 1'b1, 1'b1, V_PENDING),
            beat_row(8'hFF, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b1, 1'b1, 1'b1, V_DISABLED),
            reg_row(CFG_PREFIX_LO, 64'hFFFF_FFFF_FFFF_FF00),
            reg_row(CFG_PREFIX_HI, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(CFG_PREFIX_LEN, 64'd1),
            reg_row(CFG_RX_EN, 64'd1),
            reg_row(CFG_MAX_PAY, 64'd0),
            // One-byte prefix, empty payload, limit of zero.
            beat_row(8'h00, 1'b0, 1'b1, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b1, 1'b1, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b1, 1'b1, 1'b1, V_ACCEPT),
            beat_row(8'h01, 1'b0, 1'b1, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b1, 1'b1, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b1, 1'b1, 1'b1, V_PREFIX),
            reg_row(CFG_PREFIX_LEN, 64'd0),
            reg_row(CFG_SUFFIX_LO, 64'h0000_0000_0000_00FF),
            reg_row(CFG_SUFFIX_HI, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(CFG_SUFFIX_LEN, 64'd1),
            // One-byte suffix that does not match.
            beat_row(8'h00, 1'b0, 1'b1, 1'b1, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'h00, 1'b0, 1'b0, 1'b0, V_PENDING),
            beat_row(8'hFE, 1'b1, 1'b1, 1'b0, V_SUFFIX)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg) begin
                drain_results();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                send_beat(dir_rows[i].data, dir_rows[i].fin);
                if (dir_rows[i].typed) begin
                    typed_res.frame_byte = dir_rows[i].data;
                    typed_res.in_frame   = dir_rows[i].in_frame;
                    typed_res.packet_end = dir_rows[i].fin;
                    typed_res.verdict    = dir_rows[i].verdict;
                    expected_beats[expected_beats.size()-1] = typed_res;
                end
            end
        end

        // Segments end on a beat count, so new registers often land mid-packet.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            phase    = seg / 3;
            src_idle = (phase == 0) ? 11 : (phase == 1) ? 61 : 0;
            snk_idle = (phase == 0) ? 61 : (phase == 1) ? 11 : 0;
            configure_segment(seg);
            for (int n = 0; n < SEG_BEATS; n++) begin
                if (pending_bytes.size() == 0)
                    build_packet();
                nb = pending_bytes.pop_front();
                send_beat(nb[7:0], nb[8]);
            end
        end
        while (pending_bytes.size() != 0) begin
            nb = pending_bytes.pop_front();
            send_beat(nb[7:0], nb[8]);
        end

        drain_results();
        repeat (8) @(posedge aclk);
        error_count += expected_beats.size();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/mfd_pkg.sv
hdl/mfd_cfg_regs.sv
hdl/mfd_frame_core.sv
hdl/marked_frame_deframer.sv
verif/marked_frame_deframer_tb.sv
